FILE: rtl/u8d_pkg.sv
package u8d_pkg;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_TWO     = 3'd1;
  localparam logic [2:0] PH_THREE_A = 3'd2;
  localparam logic [2:0] PH_THREE_B = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;

  localparam logic [15:0] SUBST_CP     = 16'h003F;
  localparam logic [15:0] MIN_TWO_CP   = 16'h0080;
  localparam logic [15:0] MIN_THREE_CP = 16'h0800;
  localparam logic [2:0]  SKIP_START   = 3'd4;

  typedef struct packed {
    logic [15:0] code_point;
    logic        end_of_string;
    logic        last;
  } result_t;

  // Outcome of decoding one byte: zero, one or two results.
  typedef struct packed {
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
  } step_t;

endpackage

FILE: rtl/utf8_bmp_stream_decoder.sv
// UTF-8 to 16-bit code point decoder for one-, two- and three-octet forms.
// The input channel takes one byte per beat on data_byte_i; the output
// channel gives one code point per beat with end_of_string_o, set for the
// terminating zero byte, and last_o, set on the final result that a byte
// causes. Malformed input comes out as '?' (0x3F); a broken sequence can
// make one byte yield two results, and a two- or three-octet lead byte
// alone yields none. An accepted byte sits in an input register, is
// decoded from there once the queue holds at most two results, and lands
// in a four-entry result queue. One byte is taken per cycle as
// long as the queue holds at most two results, so a stream of one result
// per byte runs at one beat per cycle; bytes that yield two results are
// limited by the output channel's one result per cycle. Reset clears the
// decoder to idle and empties the queue and input register. When the
// receiver stalls, the head result holds steady; once the queue holds more
// than two results, in_stall_o rises to hold off further bytes. No beat is dropped.
module utf8_bmp_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_point_o,
  output logic        end_of_string_o,
  output logic        last_o
);
  import u8d_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_accept;
  logic       go;
  step_t      step;

  result_t    fifo_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q, count_d;
  logic       pop;
  result_t    head;

  assign go         = in_valid_q && (count_q <= 3'd2);
  assign in_stall_o = in_valid_q && !go;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
    end
  end

  u8d_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .byte_i (in_byte_q),
    .step_o (step)
  );

  assign head            = fifo_q[rd_ptr_q];
  assign out_valid_o     = count_q != 3'd0;
  assign code_point_o    = head.code_point;
  assign end_of_string_o = head.end_of_string;
  assign last_o          = head.last;
  assign pop             = out_valid_o && !out_stall_i;

  assign count_d = count_q + (go ? {1'b0, step.n_res} : 3'd0) - {2'd0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (go) begin
        wr_ptr_q <= wr_ptr_q + step.n_res;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && step.n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= step.res0;
      if (step.n_res == 2'd2) begin
        fifo_q[wr_ptr_q + 2'd1] <= step.res1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("result queue overflow");

  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_string_o |-> last_o && code_point_o == 16'h0000)
    else $error("end-of-string result is not the final zero result");

  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |-> count_q + {1'b0, step.n_res} <= 3'd4)
    else $error("decode pushed into a full queue");

endmodule

FILE: rtl/u8d_step.sv
module u8d_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  logic [7:0]     byte_i,
  output u8d_pkg::step_t step_o
);
  import u8d_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] partial_q, partial_d;
  logic [2:0]  skip_q, skip_d;

  logic        cont;
  logic [2:0]  skip_base;
  logic [2:0]  f_phase;
  logic [15:0] f_partial;
  logic [2:0]  f_skip;
  logic        f_emit;
  result_t     f_res;
  logic [15:0] v_low;
  logic [2:0]  skip_dec;

  assign cont      = byte_i inside {[8'h80:8'hBF]};
  assign v_low     = partial_q | {10'd0, byte_i[5:0]};
  assign skip_dec  = skip_q - 3'd1;
  // A broken skip run clears the count before the byte is decoded afresh.
  assign skip_base = (phase_q == PH_SKIP) ? 3'd0 : skip_q;

  // Decode the byte as the start of a new character.
  always_comb begin
    f_phase   = PH_IDLE;
    f_partial = partial_q;
    f_skip    = skip_base;
    f_emit    = 1'b1;
    f_res     = '{code_point: SUBST_CP, end_of_string: 1'b0, last: 1'b1};
    if (byte_i == 8'h00) begin
      f_partial = '0;
      f_skip    = '0;
      f_res     = '{code_point: 16'h0000, end_of_string: 1'b1, last: 1'b1};
    end else if (byte_i < 8'h80) begin
      f_res.code_point = {8'h00, byte_i};
    end else if (byte_i inside {[8'hC0:8'hDF]}) begin
      f_partial = {5'd0, byte_i[4:0], 6'd0};
      f_phase   = PH_TWO;
      f_emit    = 1'b0;
    end else if (byte_i inside {[8'hE0:8'hEF]}) begin
      f_partial = {byte_i[3:0], 12'd0};
      f_phase   = PH_THREE_A;
      f_emit    = 1'b0;
    end else if (byte_i inside {[8'hF0:8'hF7]}) begin
      f_phase = PH_SKIP;
      f_skip  = SKIP_START;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    partial_d = partial_q;
    skip_d    = skip_q;
    step_o    = '0;
    case (phase_q)
      PH_TWO, PH_THREE_A, PH_THREE_B: begin
        if (cont) begin
          if (phase_q == PH_THREE_A) begin
            partial_d = partial_q | {4'd0, byte_i[5:0], 6'd0};
            phase_d   = PH_THREE_B;
          end else begin
            phase_d                  = PH_IDLE;
            step_o.n_res             = 2'd1;
            step_o.res0.last         = 1'b1;
            step_o.res0.code_point   = v_low;
            if ((phase_q == PH_TWO && v_low < MIN_TWO_CP) ||
                (phase_q == PH_THREE_B && v_low < MIN_THREE_CP)) begin
              step_o.res0.code_point = SUBST_CP;
            end
          end
        end else begin
          // Broken sequence: substitute, then decode this byte as a lead.
          phase_d                = f_phase;
          partial_d              = f_partial;
          skip_d                 = f_skip;
          step_o.res0.code_point = SUBST_CP;
          step_o.res0.last       = !f_emit;
          step_o.res1            = f_res;
          step_o.n_res           = f_emit ? 2'd2 : 2'd1;
        end
      end
      PH_SKIP: begin
        if (cont) begin
          skip_d = skip_dec;
          if (skip_dec == 3'd0) begin
            phase_d = PH_IDLE;
          end
        end else begin
          phase_d      = f_phase;
          partial_d    = f_partial;
          skip_d       = f_skip;
          step_o.res0  = f_res;
          step_o.n_res = {1'b0, f_emit};
        end
      end
      default: begin
        phase_d      = f_phase;
        partial_d    = f_partial;
        skip_d       = f_skip;
        step_o.res0  = f_res;
        step_o.n_res = {1'b0, f_emit};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      partial_q <= '0;
      skip_q    <= '0;
    end else if (go_i) begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
      skip_q    <= skip_d;
    end
  end

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> skip_q != 3'd0 && skip_q <= SKIP_START)
    else $error("skip phase with an out-of-range skip count");

endmodule
